// ===== src/pv_cell_current_from_voltage_macros.svh =====
// Assertion macros shared by the solar cell current core.
`ifndef PV_CELL_CURRENT_FROM_VOLTAGE_MACROS_SVH
`define PV_CELL_CURRENT_FROM_VOLTAGE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the same clock edge outside reset.
`define PVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/pvc_pkg.sv =====
// Shared types, constants and functions of the solar cell current core.
package pvc_pkg;

  // Field and register widths.
  localparam int VoltW   = 17;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 8;
  localparam int MW      = 17;
  localparam int ScaleW  = 27;
  localparam int DivdW   = MW + ScaleW;
  localparam int QW      = 21;
  localparam int TotW    = 31;
  localparam int PW      = 17;

  // Divider arrangement: one saturation stage, then DivBits quotient bits per stage.
  localparam int DivBits   = 3;
  localparam int DivStages = QW / DivBits;

  // Stages from input transfer to output register.
  localparam int Depth = 2 + 1 + DivStages + 2 + 1;

  // log2(e) / (16 k/q) scaled by 65536.
  localparam logic [ScaleW-1:0] LOG2_SCALE = 27'd68574357;
  localparam logic [CfgW-1:0]   FULL_SUN   = 16'h8000;

  // Register reset values.
  localparam logic [CfgW-1:0] VOC_RST  = 16'd24576;
  localparam logic [CfgW-1:0] ISC_RST  = 16'd12288;
  localparam logic [CfgW-1:0] TEMP_RST = 16'd19080;
  localparam logic [CfgW-1:0] EXP_RST  = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOC  = 8'd0,
    CFG_ISC  = 8'd1,
    CFG_TEMP = 8'd2,
    CFG_EXP  = 8'd3
  } cfg_idx_e;

  // Front end result: dividend and total exposure.
  typedef struct packed {
    logic [DivdW-1:0] dividend;
    logic [TotW-1:0]  total;
  } front_t;

  // Divider result: base-2 exponent magnitude, underflow flag and total exposure.
  typedef struct packed {
    logic [QW-1:0]   quo;
    logic            sat;
    logic [TotW-1:0] total;
  } div_t;

  // Difference of total exposure and the exponential term.
  typedef struct packed {
    logic [TotW-1:0] diff;
    logic            pos;
  } exp_t;

  typedef struct packed {
    logic [CfgW-1:0] rem;
    logic            qbit;
  } div_step_t;

  // One restoring division step.
  function automatic div_step_t div_step(input logic [CfgW-1:0] rem, input logic b,
                                         input logic [CfgW-1:0] den);
    logic [CfgW:0] acc;
    div_step_t     res;
    acc = {rem, b};
    if (acc >= {1'b0, den}) begin
      acc      = acc - {1'b0, den};
      res.qbit = 1'b1;
    end else begin
      res.qbit = 1'b0;
    end
    res.rem = acc[CfgW-1:0];
    return res;
  endfunction

  // 2^(-k/16) in Q16 for k = 0..16.
  function automatic logic [PW-1:0] pow2_tab(input logic [4:0] k);
    logic [PW-1:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== src/pv_cell_current_from_voltage.sv =====
// Each item passes the front end, divider, exponent and scale stages in order to the output register.
// Throughput: one item per clock while the output is not stalled; each stage fills its bubble, so stalls lose no slot.
// The exponent division runs as a 7-stage restoring divider, 3 quotient bits a stage.
// Reset clears all valid bits and loads the four registers with their default values.
// Top level of the solar cell current core.
`include "pv_cell_current_from_voltage_macros.svh"

module pv_cell_current_from_voltage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pvc_pkg::VoltW-1:0]    terminal_voltage_i,
  input  logic signed [pvc_pkg::VoltW-1:0]    item_exposure_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [pvc_pkg::CfgW-1:0]     cell_current_o,
  input  logic                                cfg_we_i,
  input  logic        [pvc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [pvc_pkg::CfgW-1:0]     cfg_value_i
);

  localparam int CntW = $clog2(pvc_pkg::Depth + 1);

  logic [pvc_pkg::CfgW-1:0] voc_q, isc_q, temp_q, cexp_q, temp_safe;
  logic                     f_valid, f_ready, d_valid, d_ready, e_valid, e_ready, in_ready;
  pvc_pkg::front_t          f_data;
  pvc_pkg::div_t            d_data;
  pvc_pkg::exp_t            e_data;
  logic [CntW-1:0]          inflight_q;
  logic                     in_xfer, out_xfer;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voc_q  <= pvc_pkg::VOC_RST;
      isc_q  <= pvc_pkg::ISC_RST;
      temp_q <= pvc_pkg::TEMP_RST;
      cexp_q <= pvc_pkg::EXP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pvc_pkg::CFG_VOC:  voc_q  <= cfg_value_i;
        pvc_pkg::CFG_ISC:  isc_q  <= cfg_value_i;
        pvc_pkg::CFG_TEMP: temp_q <= cfg_value_i;
        pvc_pkg::CFG_EXP:  cexp_q <= cfg_value_i;
        default: ;
      endcase
    end
  end

  // A zero temperature acts as the smallest step.
  assign temp_safe  = (temp_q == '0) ? 16'd1 : temp_q;
  assign in_stall_o = !in_ready;

  pvc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .volt_i  (terminal_voltage_i),
    .expo_i  (item_exposure_i),
    .voc_i   (voc_q),
    .cexp_i  (cexp_q),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .data_o  (f_data)
  );

  pvc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_data),
    .temp_i  (temp_safe),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .data_o  (d_data)
  );

  pvc_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .ready_o (d_ready),
    .data_i  (d_data),
    .valid_o (e_valid),
    .ready_i (e_ready),
    .data_o  (e_data)
  );

  pvc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_valid),
    .ready_o (e_ready),
    .data_i  (e_data),
    .isc_i   (isc_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .cur_o   (cell_current_o)
  );

  // Count of items between input and output transfer.
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + CntW'(1);
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - CntW'(1);
    end
  end

  // Checks on pipeline occupancy and back pressure.
  `PVC_ASSERT_IMP(a_stall_only_full, in_stall_o, out_valid_o && out_stall_i, "input stalled while output free")
  `PVC_ASSERT_IMP(a_out_has_item, out_valid_o, inflight_q != '0, "result without an item in flight")
  `PVC_ASSERT(a_depth_bound, inflight_q <= CntW'(pvc_pkg::Depth), "more items in flight than stages")

endmodule

// ===== src/pvc_front.sv =====
// Input clamping, total exposure and dividend multiplication (two stages).
module pvc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [pvc_pkg::VoltW-1:0]  volt_i,
  input  logic signed [pvc_pkg::VoltW-1:0]  expo_i,
  input  logic        [pvc_pkg::CfgW-1:0]   voc_i,
  input  logic        [pvc_pkg::CfgW-1:0]   cexp_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output pvc_pkg::front_t                   data_o
);

  logic                          va_q, vb_q, en_a, en_b;
  logic [pvc_pkg::MW-1:0]        m_d, m_q;
  logic [pvc_pkg::TotW-1:0]      tot_d, tot_q;
  logic [pvc_pkg::CfgW-1:0]      ie, ce;
  logic [2*pvc_pkg::CfgW-1:0]    tprod;
  logic signed [pvc_pkg::VoltW:0] voc_s, v_s, mdiff;
  pvc_pkg::front_t               out_d, out_q;

  // A stage takes a new transfer when it is empty or its successor moves.
  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  // Voltage margin below open circuit and clamped exposure product.
  always_comb begin
    voc_s = signed'({2'b00, voc_i});
    v_s   = {volt_i[pvc_pkg::VoltW-1], volt_i};
    mdiff = voc_s - v_s;
    m_d   = (v_s > voc_s) ? '0 : mdiff[pvc_pkg::MW-1:0];
    if (expo_i[pvc_pkg::VoltW-1]) begin
      ie = '0;
    end else if (expo_i > signed'({1'b0, pvc_pkg::FULL_SUN})) begin
      ie = pvc_pkg::FULL_SUN;
    end else begin
      ie = expo_i[pvc_pkg::CfgW-1:0];
    end
    ce    = (cexp_i > pvc_pkg::FULL_SUN) ? pvc_pkg::FULL_SUN : cexp_i;
    tprod = ce * ie;
    tot_d = tprod[pvc_pkg::TotW-1:0];
  end

  // Dividend of the exponent division.
  always_comb begin
    out_d.dividend = {{pvc_pkg::ScaleW{1'b0}}, m_q} *
                     {{pvc_pkg::MW{1'b0}}, pvc_pkg::LOG2_SCALE};
    out_d.total    = tot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      m_q   <= m_d;
      tot_q <= tot_d;
    end
    if (en_b && va_q) out_q <= out_d;
  end

  assign valid_o = vb_q;
  assign data_o  = out_q;

endmodule

// ===== src/pvc_div.sv =====
// Pipelined restoring divider giving the exponent magnitude in Q16.
module pvc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  pvc_pkg::front_t                 data_i,
  input  logic [pvc_pkg::CfgW-1:0]        temp_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output pvc_pkg::div_t                   data_o
);

  localparam int NStg = pvc_pkg::DivStages + 1;
  localparam int QW   = pvc_pkg::QW;

  logic [NStg-1:0]             v_q;
  logic [NStg:0]               en;
  logic [pvc_pkg::CfgW-1:0]    rem_q [NStg];
  logic [QW-1:0]               lo_q  [NStg];
  logic [QW-1:0]               q_q   [NStg];
  logic                        sat_q [NStg];
  logic [pvc_pkg::TotW-1:0]    tot_q [NStg];
  logic                        sat_d;

  assign en[NStg] = ready_i;
  assign ready_o  = en[0];

  // Quotient at or above 32 in the integer part means the exponential underflows.
  assign sat_d = data_i.dividend >=
                 {{(pvc_pkg::DivdW-pvc_pkg::CfgW-QW){1'b0}}, temp_i, {QW{1'b0}}};

  // Saturation check stage; the remainder starts as the dividend's upper part.
  assign en[0] = !v_q[0] || en[1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      rem_q[0] <= data_i.dividend[QW +: pvc_pkg::CfgW];
      lo_q[0]  <= data_i.dividend[QW-1:0];
      q_q[0]   <= '0;
      sat_q[0] <= sat_d;
      tot_q[0] <= data_i.total;
    end
  end

  // Division stages, DivBits quotient bits each.
  for (genvar s = 1; s < NStg; s++) begin : g_stage
    logic [pvc_pkg::CfgW-1:0] rs [pvc_pkg::DivBits+1];
    logic [QW-1:0]            ls [pvc_pkg::DivBits+1];
    logic [QW-1:0]            qs [pvc_pkg::DivBits+1];

    assign rs[0] = rem_q[s-1];
    assign ls[0] = lo_q[s-1];
    assign qs[0] = q_q[s-1];

    for (genvar j = 0; j < pvc_pkg::DivBits; j++) begin : g_bit
      pvc_pkg::div_step_t st;
      assign st        = pvc_pkg::div_step(rs[j], ls[j][QW-1], temp_i);
      assign rs[j+1]   = st.rem;
      assign ls[j+1]   = {ls[j][QW-2:0], 1'b0};
      assign qs[j+1]   = {qs[j][QW-2:0], st.qbit};
    end

    assign en[s] = !v_q[s] || en[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && v_q[s-1]) begin
        rem_q[s] <= rs[pvc_pkg::DivBits];
        lo_q[s]  <= ls[pvc_pkg::DivBits];
        q_q[s]   <= qs[pvc_pkg::DivBits];
        sat_q[s] <= sat_q[s-1];
        tot_q[s] <= tot_q[s-1];
      end
    end
  end

  assign valid_o      = v_q[NStg-1];
  assign data_o.quo   = q_q[NStg-1];
  assign data_o.sat   = sat_q[NStg-1];
  assign data_o.total = tot_q[NStg-1];

endmodule

// ===== src/pvc_exp.sv =====
// Table interpolation of 2^-z and subtraction from the total exposure (two stages).
module pvc_exp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pvc_pkg::div_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pvc_pkg::exp_t   data_o
);

  logic                         va_q, vb_q, en_a, en_b;
  logic [3:0]                   idx;
  logic [11:0]                  frac;
  logic [pvc_pkg::PW-1:0]       hi, lo, dlt, p_d, p_q;
  logic [29:0]                  iprod;
  logic [4:0]                   n_q;
  logic                         sat_q;
  logic [pvc_pkg::TotW-1:0]     tot_q, e30;
  pvc_pkg::exp_t                out_d, out_q;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  // Linear interpolation between neighboring table entries.
  always_comb begin
    idx   = data_i.quo[15:12];
    frac  = data_i.quo[11:0];
    hi    = pvc_pkg::pow2_tab({1'b0, idx});
    lo    = pvc_pkg::pow2_tab({1'b0, idx} + 5'd1);
    dlt   = hi - lo;
    iprod = 30'(dlt) * 30'(frac) + 30'd2048;
    p_d   = hi - iprod[pvc_pkg::PW+11:12];
  end

  // Integer part shifts the fraction; compare against the total exposure.
  always_comb begin
    e30        = sat_q ? '0 : ({p_q, 14'b0} >> n_q);
    out_d.pos  = tot_q > e30;
    out_d.diff = tot_q - e30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      p_q   <= p_d;
      n_q   <= data_i.quo[20:16];
      sat_q <= data_i.sat;
      tot_q <= data_i.total;
    end
    if (en_b && va_q) out_q <= out_d;
  end

  assign valid_o = vb_q;
  assign data_o  = out_q;

endmodule

// ===== src/pvc_scale.sv =====
// Scaling by the short circuit current, clamping and output register.
module pvc_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  pvc_pkg::exp_t                data_i,
  input  logic [pvc_pkg::CfgW-1:0]     isc_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [pvc_pkg::CfgW-1:0]     cur_o
);

  logic                        v_q, en;
  logic [47:0]                 prod;
  logic [pvc_pkg::CfgW:0]      c17;
  logic [pvc_pkg::CfgW-1:0]    cur_d, cur_q;

  assign en      = !v_q || !stall_i;
  assign ready_o = en;

  // Rounded product in amperes, limited to the short circuit current.
  always_comb begin
    prod = 48'(isc_i) * 48'(data_i.diff) + 48'h2000_0000;
    c17  = prod[46:30];
    if (!data_i.pos) begin
      cur_d = '0;
    end else if (c17 > {1'b0, isc_i}) begin
      cur_d = isc_i;
    end else begin
      cur_d = c17[pvc_pkg::CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) cur_q <= cur_d;
  end

  assign valid_o = v_q;
  assign cur_o   = cur_q;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the solar cell current core.
`timescale 1ns / 100ps

module tb_top;

  localparam int NumRandom = 1200;
  localparam int IdleLimit = 4000;
  localparam int Latency   = 13;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic signed [pvc_pkg::VoltW-1:0] terminal_voltage_i = '0;
  logic signed [pvc_pkg::VoltW-1:0] item_exposure_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [pvc_pkg::CfgW-1:0]         cell_current_o;
  logic                             cfg_we_i = 1'b0;
  logic [pvc_pkg::CfgIdxW-1:0]      cfg_index_i = '0;
  logic [pvc_pkg::CfgW-1:0]         cfg_value_i = '0;

  pv_cell_current_from_voltage i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [pvc_pkg::CfgW-1:0] voc_q, isc_q, temp_q, exp_q;

  logic [pvc_pkg::CfgW-1:0] current_queue[$];
  int unsigned     error_count;
  int unsigned     result_count;
  int unsigned     idle_cycles;
  bit              rx_hold;
  bit              calm;

  typedef struct {
    int  volt;
    int  expo;
    bit  known;
    int  current;
  } stim_row_t;

  // 2^(-k/16) in Q16.
  function automatic longint unsigned exp2_entry(int k);
    longint unsigned tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                 48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                 35734, 34219, 32768};
    return tab[k];
  endfunction

  // Expected current for one voltage and exposure sample.
  function automatic logic [pvc_pkg::CfgW-1:0] predict_current(int volt, int expo);
    longint          vc, xe;
    longint unsigned m, z, tot, e30, cur, tk, hi, lo, p, n, r;
    int              i;
    vc = (volt > int'(voc_q)) ? longint'(voc_q) : longint'(volt);
    m = voc_q - vc;
    xe = (expo < 0) ? 0 : (expo > 32768 ? 32768 : expo);
    tot = ((exp_q > pvc_pkg::FULL_SUN) ? pvc_pkg::FULL_SUN : exp_q) * xe;
    tk = (temp_q == 0) ? 1 : temp_q;
    z = (m * 64'd68574357) / tk;
    n = z >> 16;
    if (n >= 32) begin
      e30 = 0;
    end else begin
      i = int'((z >> 12) & 15);
      r = z & 12'hFFF;
      hi = exp2_entry(i);
      lo = exp2_entry(i + 1);
      p = hi - (((hi - lo) * r + 2048) >> 12);
      e30 = (p << 14) >> n;
    end
    if (tot <= e30) return '0;
    cur = (isc_q * (tot - e30) + (64'd1 << 29)) >> 30;
    if (cur > isc_q) cur = isc_q;
    return cur[pvc_pkg::CfgW-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Register write while the pipeline is empty.
  task automatic write_reg(pvc_pkg::cfg_idx_e idx, logic [pvc_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_value_i <= val;
    case (idx)
      pvc_pkg::CFG_VOC:  voc_q = val;
      pvc_pkg::CFG_ISC:  isc_q = val;
      pvc_pkg::CFG_TEMP: temp_q = val;
      pvc_pkg::CFG_EXP:  exp_q = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one item and returns at the edge of its transfer; valid stays up
  // so that the next item can follow directly.
  task automatic send_sample(int volt, int expo, bit idle);
    if (idle) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    terminal_voltage_i <= pvc_pkg::VoltW'(volt);
    item_exposure_i <= pvc_pkg::VoltW'(expo);
    current_queue.push_back(predict_current(volt, expo));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (current_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Receiver stall: random, with a calm stretch and one long hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || (!calm && $urandom_range(99) < 31);
  end

  // Result checker and idle watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout with %0d results pending", current_queue.size());
        $display("FAILURE");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        result_count++;
        if (current_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected current %0d", cell_current_o));
        end else begin
          if (cell_current_o !== current_queue[0])
            report_mismatch($sformatf("current %0d, expected %0d", cell_current_o,
                                      current_queue[0]));
          void'(current_queue.pop_front());
        end
      end
    end
  end

  stim_row_t directed[$];

  initial begin
    int          volt, expo;
    logic [pvc_pkg::CfgW-1:0] got;
    rx_hold = 0;
    calm = 0;
    voc_q = pvc_pkg::VOC_RST;
    isc_q = pvc_pkg::ISC_RST;
    temp_q = pvc_pkg::TEMP_RST;
    exp_q = pvc_pkg::EXP_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; voltage at or above Voc gives zero current.
    directed = '{
      '{24576, 32768, 1, 0}, '{65535, 32768, 1, 0}, '{-65536, 32768, 1, 12288},
      '{-65536, -65536, 1, 0}, '{-65536, 65535, 1, 12288}, '{0, 0, 1, 0},
      '{0, 32768, 0, 0}, '{24000, 32768, 0, 0}, '{20000, 16384, 0, 0},
      '{24575, 65535, 0, 0}, '{-1, 32767, 0, 0}, '{12000, 1, 0, 0}
    };
    foreach (directed[k]) begin
      got = predict_current(directed[k].volt, directed[k].expo);
      if (directed[k].known && got != directed[k].current)
        report_mismatch($sformatf("row %0d predicts %0d", k, got));
      send_sample(directed[k].volt, directed[k].expo, 1'b1);
    end
    drain();

    // Extreme settings: zero and maximum temperature, exposure above full sun, zero and maximum Voc and Isc.
    write_reg(pvc_pkg::CFG_TEMP, 16'd0);
    write_reg(pvc_pkg::CFG_EXP, 16'hFFFF);
    write_reg(pvc_pkg::CFG_ISC, 16'hFFFF);
    send_sample(24575, 32768, 1'b0);
    send_sample(-65536, 65535, 1'b0);
    drain();
    write_reg(pvc_pkg::CFG_VOC, 16'd0);
    write_reg(pvc_pkg::CFG_TEMP, 16'hFFFF);
    send_sample(-65536, 32768, 1'b0);
    send_sample(-1, 20000, 1'b0);
    drain();
    write_reg(pvc_pkg::CFG_VOC, 16'hFFFF);
    write_reg(pvc_pkg::CFG_ISC, 16'd0);
    send_sample(-65536, 32768, 1'b0);
    drain();
    // Index past the register list is ignored.
    write_reg(pvc_pkg::cfg_idx_e'(8'd7), 16'd5);

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(pvc_pkg::CFG_VOC, ph == 0 ? pvc_pkg::VOC_RST
                                          : pvc_pkg::CfgW'($urandom_range(65535)));
      write_reg(pvc_pkg::CFG_ISC, ph == 0 ? pvc_pkg::ISC_RST
                                          : pvc_pkg::CfgW'($urandom_range(65535)));
      write_reg(pvc_pkg::CFG_TEMP, ph == 0 ? pvc_pkg::TEMP_RST
                                           : pvc_pkg::CfgW'($urandom_range(65535)));
      write_reg(pvc_pkg::CFG_EXP, $urandom_range(3) == 0
                                  ? pvc_pkg::CfgW'($urandom_range(65535))
                                  : pvc_pkg::CfgW'($urandom_range(32768)));
      calm = (ph == 2);
      for (int k = 0; k < NumRandom / 6; k++) begin
        if (ph == 3 && k == 10) begin
          fork
            begin
              rx_hold = 1;
              repeat (60) @(posedge clk_i);
              rx_hold = 0;
            end
          join_none
        end
        case ($urandom_range(3))
          0: volt = $urandom_range(131071) - 65536;
          default: volt = int'(voc_q) - int'($urandom_range(3000));
        endcase
        expo = ($urandom_range(4) == 0) ? $urandom_range(131071) - 65536
                                        : $urandom_range(32768);
        send_sample(volt, expo, !calm);
      end
      drain();
    end

    $display("Covered %0d results over directed rows, register extremes and six random",
             result_count);
    $display("configuration phases, with random stalls and one long output hold-off.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
